/* rtl/spow_pkg.sv */
// ----------------------------------------------------------------------------
// spow_pkg
// Shared constants and hash helpers for the SYN proof-of-work filter.
// ----------------------------------------------------------------------------
`default_nettype none

package spow_pkg;

  // frame offsets, counted from the ethernet destination
  localparam logic [5:0] PosEtherHi   = 6'd12;
  localparam logic [5:0] PosEtherLo   = 6'd13;
  localparam logic [5:0] PosProtocol  = 6'd23;
  localparam logic [5:0] PosDigestLo  = 6'd26;
  localparam logic [5:0] PosDigestHi  = 6'd45;
  localparam logic [5:0] PosTailRound = 6'd46;
  localparam logic [5:0] PosFlags     = 6'd47;
  localparam logic [5:0] PosAval1     = 6'd47;
  localparam logic [5:0] PosAval2     = 6'd48;
  localparam logic [5:0] PosAval3     = 6'd49;
  localparam logic [5:0] FullHdrLen   = 6'd54;
  localparam logic [5:0] LastHdrPos   = 6'd53;

  // match values
  localparam logic [7:0] EtherHiIpv4  = 8'h08;
  localparam logic [7:0] EtherLoIpv4  = 8'h00;
  localparam logic [7:0] ProtoTcp     = 8'd6;
  localparam logic [4:0] FlagsBareSyn = 5'h02;

  // hash seed: byte length of the hashed data, digest words plus zero words
  localparam logic [31:0] DigestLen   = 32'd40;

  // low position bits of the byte that completes a digest word, and of the next byte
  localparam logic [1:0] LaneLastBits  = 2'b01;
  localparam logic [1:0] LaneFirstBits = 2'b10;

  // one superfasthash word round
  function automatic logic [31:0] word_round(input logic [31:0] h, input logic [31:0] w);
    logic [31:0] a;
    logic [31:0] t;
    logic [31:0] m;
    a = h + {16'b0, w[15:0]};
    t = {5'b0, w[31:16], 11'b0} ^ a;
    m = {a[15:0], 16'b0} ^ t;
    return m + (m >> 11);
  endfunction

  // avalanche, split into three steps of one add each
  function automatic logic [31:0] aval_step1(input logic [31:0] h);
    logic [31:0] x;
    x = h ^ (h << 3);
    return x + (x >> 5);
  endfunction

  function automatic logic [31:0] aval_step2(input logic [31:0] h);
    logic [31:0] x;
    x = h ^ (h << 4);
    return x + (x >> 17);
  endfunction

  function automatic logic [31:0] aval_step3(input logic [31:0] h);
    logic [31:0] x;
    x = h ^ (h << 25);
    return x + (x >> 6);
  endfunction

endpackage

`default_nettype wire

/* rtl/spow_frame_if.sv */
// ----------------------------------------------------------------------------
// spow_frame_if
// Byte stream channel carrying one frame byte per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface spow_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

`default_nettype wire

/* rtl/spow_result_if.sv */
// ----------------------------------------------------------------------------
// spow_result_if
// Per-frame verdict channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface spow_result_if;
  logic        valid;
  logic        ready;
  logic        drop_frame;
  logic        was_bare_syn;
  logic [31:0] digest_hash;

  modport source (output valid, output drop_frame, output was_bare_syn,
                  output digest_hash, input ready);
  modport sink   (input valid, input drop_frame, input was_bare_syn,
                  input digest_hash, output ready);
endinterface

`default_nettype wire

/* rtl/spow_cfg_if.sv */
// ----------------------------------------------------------------------------
// spow_cfg_if
// Write channel for the work threshold register.
// ----------------------------------------------------------------------------
`default_nettype none

interface spow_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] work_threshold;

  modport source (output valid, output work_threshold, input ready);
  modport sink   (input valid, input work_threshold, output ready);
endinterface

`default_nettype wire

/* rtl/syn_proof_of_work_filter.sv */
// The verdict is registered and presented in the cycle after the last byte is accepted.
// Throughput: one frame byte per cycle; each byte touches the running hash at most once,
// with a digest word round, the deferred zero-word round, or one avalanche step.
// A waiting verdict holds off every frame byte until it is taken; a new last byte can land
// in the same cycle the waiting verdict is taken.
// Reset (rst_ni low, async): threshold 0, header state and hash reset, no result pending.
// ----------------------------------------------------------------------------
// syn_proof_of_work_filter
// Streams ethernet frames, hashes the digest of bare TCP SYNs and drops
// frames whose hash falls below the work threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module syn_proof_of_work_filter (
  input  wire            clk_i,
  input  wire            rst_ni,
  spow_frame_if.sink     frame_i,
  spow_cfg_if.sink       cfg_i,
  spow_result_if.source  result_o
);
  import spow_pkg::*;

  logic        fire;
  logic        is_last;
  logic [7:0]  b;
  logic [5:0]  pos_q, pos_d;
  logic        eth_q, eth_d;
  logic        proto_q, proto_d;
  logic [4:0]  flags_q, flags_d;
  logic [23:0] partial_q, partial_d;
  logic [31:0] hash_q, hash_d;
  logic [31:0] thresh_q;
  logic        in_digest;
  logic        zero_round;
  logic        bare_syn;
  logic        out_valid_q;
  logic        out_drop_q;
  logic        out_syn_q;
  logic [31:0] out_hash_q;

  // handshakes
  assign frame_i.ready = !out_valid_q || result_o.ready;
  assign fire          = frame_i.valid && frame_i.ready;
  assign b             = frame_i.frame_byte;
  assign is_last       = frame_i.frame_end;
  assign cfg_i.ready   = 1'b1;

  // position decode
  assign in_digest  = (pos_q >= PosDigestLo) && (pos_q <= PosDigestHi);
  assign zero_round = ((pos_q > PosDigestLo) && (pos_q <= PosTailRound)
                       && (pos_q[1:0] == LaneFirstBits));

  // per-frame state update
  always_comb begin
    pos_d     = pos_q;
    eth_d     = eth_q;
    proto_d   = proto_q;
    flags_d   = flags_q;
    partial_d = partial_q;
    hash_d    = hash_q;
    if (fire) begin
      if (is_last) begin
        pos_d   = '0;
        eth_d   = 1'b0;
        proto_d = 1'b0;
        flags_d = '0;
        hash_d  = DigestLen;
      end else begin
        if (pos_q < FullHdrLen) begin
          pos_d = pos_q + 6'd1;
        end
        if (pos_q == PosEtherHi) begin
          eth_d = (b == EtherHiIpv4);
        end
        if (pos_q == PosEtherLo) begin
          eth_d = eth_q && (b == EtherLoIpv4);
        end
        if (pos_q == PosProtocol) begin
          proto_d = (b == ProtoTcp);
        end
        if (pos_q == PosFlags) begin
          flags_d = b[4:0];
        end
        // digest bytes: gather three, round on the fourth
        if (in_digest) begin
          case (pos_q[1:0])
            2'b10:   partial_d[7:0]   = b;
            2'b11:   partial_d[15:8]  = b;
            2'b00:   partial_d[23:16] = b;
            default: partial_d        = partial_q;
          endcase
        end
        // hash schedule, at most one step per byte
        if (in_digest && (pos_q[1:0] == LaneLastBits)) begin
          hash_d = word_round(hash_q, {b, partial_q});
        end else if (zero_round) begin
          hash_d = word_round(hash_q, 32'd0);
        end else if (pos_q == PosAval1) begin
          hash_d = aval_step1(hash_q);
        end else if (pos_q == PosAval2) begin
          hash_d = aval_step2(hash_q);
        end else if (pos_q == PosAval3) begin
          hash_d = aval_step3(hash_q);
        end
      end
    end
  end

  // verdict for the current last byte
  assign bare_syn = (pos_q >= LastHdrPos) && eth_q && proto_q && (flags_q == FlagsBareSyn);

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      eth_q   <= 1'b0;
      proto_q <= 1'b0;
      flags_q <= '0;
      hash_q  <= DigestLen;
    end else begin
      pos_q   <= pos_d;
      eth_q   <= eth_d;
      proto_q <= proto_d;
      flags_q <= flags_d;
      hash_q  <= hash_d;
    end
  end

  // digest byte collector
  always_ff @(posedge clk_i) begin
    partial_q <= partial_d;
  end

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= '0;
    end else if (cfg_i.valid) begin
      thresh_q <= cfg_i.work_threshold;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && is_last) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && is_last) begin
      out_syn_q  <= bare_syn;
      out_drop_q <= bare_syn && (hash_q < thresh_q);
      out_hash_q <= bare_syn ? hash_q : 32'd0;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.drop_frame   = out_drop_q;
  assign result_o.was_bare_syn = out_syn_q;
  assign result_o.digest_hash  = out_hash_q;

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SYN proof-of-work filter. Streams hand-built
// and random frames byte by byte, predicts each frame verdict with its own
// hash model and compares every verdict field by field.
// ----------------------------------------------------------------------------
import spow_pkg::*;

typedef struct packed {
  logic        drop_frame;
  logic        was_bare_syn;
  logic [31:0] digest_hash;
} verdict_t;

// verdict predictor plus the queue of verdicts still owed by the block
class verdict_scoreboard;
  logic [31:0] work_threshold;
  logic [5:0]  byte_pos;
  logic        ether_ok;
  logic        proto_ok;
  logic [7:0]  flag_bits;
  logic [23:0] partial_word;
  logic [31:0] running_hash;
  verdict_t    expected_verdicts[$];
  int          errors;

  function new();
    work_threshold = '0;
    errors = 0;
    clear_frame();
  endfunction

  function void clear_frame();
    byte_pos = '0;
    ether_ok = 1'b0;
    proto_ok = 1'b0;
    flag_bits = '0;
    partial_word = '0;
    running_hash = DigestLen;
  endfunction

  // one superfasthash round over a 32-bit digest word
  function logic [31:0] mix_word(input logic [31:0] h, input logic [31:0] w);
    logic [31:0] hi_half;
    logic [31:0] t;
    hi_half = {16'h0, w[31:16]};
    h = h + {16'h0, w[15:0]};
    t = (hi_half << 11) ^ h;
    h = (h << 16) ^ t;
    return h + (h >> 11);
  endfunction

  // final avalanche
  function logic [31:0] finish_hash(input logic [31:0] h);
    h = h ^ (h << 3);
    h = h + (h >> 5);
    h = h ^ (h << 4);
    h = h + (h >> 17);
    h = h ^ (h << 25);
    h = h + (h >> 6);
    return h;
  endfunction

  // accepted frame byte request
  function void note_byte(input logic [7:0] b, input logic last);
    logic [5:0]  pos;
    logic [5:0]  offset;
    logic [1:0]  lane;
    logic [31:0] h;
    verdict_t    v;
    pos = byte_pos;
    if (pos == PosEtherHi) begin
      ether_ok = (b == EtherHiIpv4);
    end else if (pos == PosEtherLo) begin
      ether_ok = ether_ok && (b == EtherLoIpv4);
    end else if (pos == PosProtocol) begin
      proto_ok = (b == ProtoTcp);
    end else if (pos == PosFlags) begin
      flag_bits = b;
    end

    // digest bytes: every fourth byte closes a word, then the zero fill word
    if (pos >= PosDigestLo && pos <= PosDigestHi) begin
      offset = pos - PosDigestLo;
      lane = offset[1:0];
      if (lane == 2'd3) begin
        running_hash = mix_word(mix_word(running_hash, {b, partial_word}), 32'h0);
        partial_word = '0;
      end else begin
        partial_word[8*lane +: 8] = b;
      end
    end

    if (pos < FullHdrLen) byte_pos = pos + 6'd1;

    if (last) begin
      v = '0;
      if (byte_pos >= FullHdrLen && ether_ok && proto_ok &&
          flag_bits[4:0] == FlagsBareSyn) begin
        h = finish_hash(running_hash);
        v.drop_frame = (h < work_threshold);
        v.was_bare_syn = 1'b1;
        v.digest_hash = h;
      end
      expected_verdicts.push_back(v);
      clear_frame();
    end
  endfunction

  // accepted verdict from the block
  function void check_verdict(input logic drop, input logic syn, input logic [31:0] hash);
    verdict_t want;
    if (expected_verdicts.size() == 0) begin
      $display("%0t: verdict with none expected: drop %0b syn %0b hash %h",
               $time, drop, syn, hash);
      errors++;
      return;
    end
    want = expected_verdicts.pop_front();
    if (drop !== want.drop_frame) begin
      $display("%0t: drop_frame expected %0b got %0b", $time, want.drop_frame, drop);
      errors++;
    end
    if (syn !== want.was_bare_syn) begin
      $display("%0t: was_bare_syn expected %0b got %0b", $time, want.was_bare_syn, syn);
      errors++;
    end
    if (hash !== want.digest_hash) begin
      $display("%0t: digest_hash expected %h got %h", $time, want.digest_hash, hash);
      errors++;
    end
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit   = 2000;
  localparam int HoldCycles  = 300;
  localparam int HoldAtByte  = 1100;
  localparam int DrainCycles = 4;
  localparam int PhaseBytes  = 300;

  // tcp flag bits
  localparam logic [7:0] FlagFin   = 8'h01;
  localparam logic [7:0] FlagSyn   = 8'h02;
  localparam logic [7:0] FlagRst   = 8'h04;
  localparam logic [7:0] FlagPsh   = 8'h08;
  localparam logic [7:0] FlagAck   = 8'h10;
  localparam logic [7:0] FlagsHigh = 8'hE0;

  typedef enum {KindBareSyn, KindBadEther, KindBadProto, KindBadFlags, KindNoise} frame_kind_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  verdict_scoreboard board;
  logic       steady = 1'b0;
  int         bytes_sent = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;
  int         idle_cycles = 0;
  logic [7:0] frame_bytes[$];

  spow_frame_if  frame_ch();
  spow_cfg_if    cfg_ch();
  spow_result_if result_ch();

  syn_proof_of_work_filter i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .frame_i  (frame_ch),
    .cfg_i    (cfg_ch),
    .result_o (result_ch)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // receiver: random ready, one long hold-off while frames keep coming
  initial begin
    result_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && bytes_sent >= HoldAtByte) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= steady || ($urandom_range(0, 99) >= 17);
      end
    end
  end

  // verdict check
  always @(posedge clk_i) begin
    if (rst_ni && result_ch.valid && result_ch.ready)
      board.check_verdict(result_ch.drop_frame, result_ch.was_bare_syn,
                          result_ch.digest_hash);
  end

  // watchdog on cycles without any request accepted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((frame_ch.valid && frame_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
          (result_ch.valid && result_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  // threshold write, called at a falling edge with the block idle
  task automatic write_threshold(input logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.work_threshold <= value;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    board.work_threshold = value;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // one byte request, with an occasional gap ahead of it
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!steady && $urandom_range(0, 99) < 17) begin
      frame_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    frame_ch.valid <= 1'b1;
    frame_ch.frame_byte <= b;
    frame_ch.frame_end <= last;
    @(posedge clk_i);
    while (!frame_ch.ready) @(posedge clk_i);
    board.note_byte(b, last);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  task automatic put_byte(input int idx, input logic [7:0] value);
    if (idx < frame_bytes.size()) frame_bytes[idx] = value;
  endtask

  // random frame content with the header fields set by kind
  task automatic build_frame(input frame_kind_e kind, input int len);
    logic [7:0] flag_byte;
    logic [7:0] flip;
    frame_bytes.delete();
    for (int i = 0; i < len; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
    if (kind != KindNoise) begin
      flip = 8'($urandom_range(1, 255));
      flag_byte = {3'($urandom_range(0, 7)), FlagsBareSyn};
      put_byte(PosEtherHi, EtherHiIpv4);
      put_byte(PosEtherLo, EtherLoIpv4);
      put_byte(PosProtocol, ProtoTcp);
      case (kind)
        KindBadEther: begin
          if ($urandom_range(0, 1)) put_byte(PosEtherHi, EtherHiIpv4 ^ flip);
          else put_byte(PosEtherLo, EtherLoIpv4 ^ flip);
        end
        KindBadProto: begin
          put_byte(PosProtocol, ProtoTcp ^ flip);
        end
        KindBadFlags: begin
          flag_byte[4:0] = FlagsBareSyn ^ 5'($urandom_range(1, 31));
        end
        default: begin
        end
      endcase
      put_byte(PosFlags, flag_byte);
    end
  endtask

  // minimal bare syn with one byte overridden
  task automatic send_syn_with(input int idx, input logic [7:0] value);
    build_frame(KindBareSyn, FullHdrLen);
    put_byte(idx, value);
    send_frame();
  endtask

  task automatic send_syn_digest(input logic [7:0] fill);
    build_frame(KindBareSyn, FullHdrLen);
    for (int i = PosDigestLo; i <= PosDigestHi; i++) put_byte(i, fill);
    send_frame();
  endtask

  // random frames, mostly well-formed bare syns
  task automatic run_random(input int budget);
    int          start;
    int          pick;
    int          len;
    frame_kind_e kind;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      pick = $urandom_range(0, 99);
      kind = (pick < 65) ? KindBareSyn : (pick < 72) ? KindBadEther :
             (pick < 79) ? KindBadProto : (pick < 90) ? KindBadFlags : KindNoise;
      pick = $urandom_range(0, 99);
      if (pick < 15) len = $urandom_range(1, FullHdrLen - 1);
      else if (pick < 20) len = $urandom_range(FullHdrLen + 1, 120);
      else len = $urandom_range(FullHdrLen, FullHdrLen + 8);
      build_frame(kind, len);
      send_frame();
    end
  endtask

  // wait out every owed verdict plus the pipeline tail
  task automatic drain();
    frame_ch.valid <= 1'b0;
    while (board.expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    board = new();
    frame_ch.valid = 1'b0;
    frame_ch.frame_byte = '0;
    frame_ch.frame_end = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.work_threshold = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed frames with the highest threshold
    write_threshold('1);
    build_frame(KindNoise, 1);
    send_frame();
    build_frame(KindBareSyn, FullHdrLen - 1);
    send_frame();
    send_syn_digest(8'hFF);
    send_syn_digest(8'h00);
    send_syn_with(PosEtherHi, ~EtherHiIpv4);
    send_syn_with(PosEtherLo, ~EtherLoIpv4);
    send_syn_with(PosProtocol, ~ProtoTcp);
    send_syn_with(PosFlags, FlagSyn | FlagAck);
    send_syn_with(PosFlags, FlagSyn | FlagFin);
    send_syn_with(PosFlags, FlagSyn | FlagRst);
    send_syn_with(PosFlags, FlagSyn | FlagPsh);
    send_syn_with(PosFlags, FlagsHigh | FlagSyn);
    build_frame(KindBareSyn, 90);
    send_frame();
    drain();

    // zero threshold, no idling on either side
    write_threshold('0);
    steady = 1'b1;
    run_random(PhaseBytes);
    drain();
    steady = 1'b0;

    write_threshold($urandom);
    run_random(PhaseBytes);
    drain();

    write_threshold(32'h8000_0000);
    run_random(PhaseBytes);
    drain();

    write_threshold($urandom);
    run_random(PhaseBytes);
    drain();

    if (board.errors == 0 && board.expected_verdicts.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* syn_proof_of_work_filter.f */
rtl/spow_pkg.sv
rtl/spow_frame_if.sv
rtl/spow_result_if.sv
rtl/spow_cfg_if.sv
rtl/syn_proof_of_work_filter.sv
dv/tb_top.sv
